@@ hw/rtl/sha1sh_pkg.sv @@
package sha1sh_pkg;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 160;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] H_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_PHASE1 = 7'd20;
    localparam logic [6:0] ROUND_PHASE2 = 7'd40;
    localparam logic [6:0] ROUND_PHASE3 = 7'd60;
    localparam logic [6:0] LAST_ROUND   = 7'd79;

    localparam logic [31:0] PAD_MARK = 32'h80000000;
    localparam logic [3:0]  LEN_SLOT = 4'd14;
    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;

    // One word headed for the block buffer; closes marks the length word
    // that ends a message.
    typedef struct packed {
        logic [31:0] word;
        logic        closes;
    } cmd_t;

    function automatic logic [31:0] mix_fn(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < ROUND_PHASE1) begin
            f = (b & c) | (~b & d);
        end else if (t < ROUND_PHASE2) begin
            f = b ^ c ^ d;
        end else if (t < ROUND_PHASE3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < ROUND_PHASE1) begin
            k = K_ROUND0;
        end else if (t < ROUND_PHASE2) begin
            k = K_ROUND1;
        end else if (t < ROUND_PHASE3) begin
            k = K_ROUND2;
        end else begin
            k = K_ROUND3;
        end
        return k;
    endfunction

    // Keeps the leading nbytes bytes of a short last word and appends the pad marker.
    function automatic logic [31:0] trim_word(input logic [31:0] data, input logic [1:0] nbytes);
        logic [31:0] w;
        unique case (nbytes)
            2'd0: w = 32'h80000000;
            2'd1: w = {data[31:24], 24'h800000};
            2'd2: w = {data[31:16], 16'h8000};
            2'd3: w = {data[31:8], 8'h80};
            default: w = 32'h80000000;
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/sha1_stream_hasher_core.sv @@
// SHA-1 hasher for a stream of big-endian 32-bit message words. The front end
// takes one word per cycle into a short word queue while the queue has room
// and no padding is pending, adding the 0x80 marker, zero fill and the 64-bit
// bit length after the word flagged with s_tlast; a last word carries 0 to 4
// valid leading bytes (larger counts act as 4), and earlier words are always
// taken as four bytes. The back end loads one queued word per cycle, when the
// queue is not empty, into a 16-word schedule window, runs the 80 rounds of a
// block at one round per cycle and adds the result into the chaining value,
// taking no new word until that add is done; the input stalls whenever the
// queue is full. The padding after a last word adds two to eighteen queued
// words, so a message ends with one or two extra compressions before the
// digest H0..H4 appears as a single request on the m_ side, then a new message.
module sha1_stream_hasher_core #(
    parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: data_word [31:0], bytes_valid [34:32], zero [39:35]
    input  logic [sha1sh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: digest_h0 [31:0], digest_h1 [63:32], digest_h2 [95:64],
    //          digest_h3 [127:96], digest_h4 [159:128]
    output logic [sha1sh_pkg::M_TDATA_W-1:0] m_tdata
);
    import sha1sh_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    sha1sh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    sha1sh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_cmd   (pop_cmd)
    );

    sha1sh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/sha1sh_front.sv @@
module sha1sh_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sha1sh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                             s_tlast,
    output logic                             push_valid,
    input  logic                             push_ready,
    output sha1sh_pkg::cmd_t                 push_cmd
);
    import sha1sh_pkg::*;

    typedef enum logic [2:0] {
        F_TAKE,
        F_MARK,
        F_ZERO,
        F_LEN_HI,
        F_LEN_LO
    } front_state_t;

    front_state_t state_reg;
    logic [63:0]  bitlen_reg;
    logic [3:0]   idx_reg;

    logic [2:0]   bytes_in;
    logic [2:0]   nbytes;
    logic         push_fire;
    logic         take_fire;

    always_comb begin
        bytes_in = s_tdata[34:32];
        // Counts above four saturate, and a word that is not last is always full.
        if (!s_tlast || bytes_in > FULL_WORD_BYTES) begin
            nbytes = FULL_WORD_BYTES;
        end else begin
            nbytes = bytes_in;
        end
    end

    always_comb begin
        push_valid      = 1'b0;
        push_cmd.word   = '0;
        push_cmd.closes = 1'b0;
        unique case (state_reg)
            F_TAKE: begin
                push_valid = s_tvalid;
                if (s_tlast && nbytes != FULL_WORD_BYTES) begin
                    push_cmd.word = trim_word(s_tdata[31:0], nbytes[1:0]);
                end else begin
                    push_cmd.word = s_tdata[31:0];
                end
            end
            F_MARK: begin
                push_valid    = 1'b1;
                push_cmd.word = PAD_MARK;
            end
            F_ZERO: begin
                push_valid = (idx_reg != LEN_SLOT);
            end
            F_LEN_HI: begin
                push_valid    = 1'b1;
                push_cmd.word = bitlen_reg[63:32];
            end
            F_LEN_LO: begin
                push_valid      = 1'b1;
                push_cmd.word   = bitlen_reg[31:0];
                push_cmd.closes = 1'b1;
            end
            default: begin
                push_valid = 1'b0;
            end
        endcase
    end

    assign s_tready  = (state_reg == F_TAKE) && push_ready;
    assign push_fire = push_valid && push_ready;
    assign take_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_TAKE;
            bitlen_reg <= '0;
            idx_reg    <= '0;
        end else begin
            if (push_fire) begin
                idx_reg <= idx_reg + 4'd1;
            end
            unique case (state_reg)
                F_TAKE: begin
                    if (take_fire) begin
                        bitlen_reg <= bitlen_reg + {58'd0, nbytes, 3'b000};
                        if (s_tlast) begin
                            state_reg <= (nbytes == FULL_WORD_BYTES) ? F_MARK : F_ZERO;
                        end
                    end
                end
                F_MARK: begin
                    if (push_ready) begin
                        state_reg <= F_ZERO;
                    end
                end
                F_ZERO: begin
                    if (idx_reg == LEN_SLOT) begin
                        state_reg <= F_LEN_HI;
                    end
                end
                F_LEN_HI: begin
                    if (push_ready) begin
                        state_reg <= F_LEN_LO;
                    end
                end
                F_LEN_LO: begin
                    if (push_ready) begin
                        state_reg  <= F_TAKE;
                        bitlen_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= F_TAKE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/sha1sh_fifo.sv @@
module sha1sh_fifo #(
    parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  sha1sh_pkg::cmd_t wr_cmd,
    output logic             rd_valid,
    input  logic             rd_ready,
    output sha1sh_pkg::cmd_t rd_cmd
);
    import sha1sh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          wr_fire;
    logic          rd_fire;

    assign wr_ready = (count_reg != (AW + 1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/sha1sh_back.sv @@
module sha1sh_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  sha1sh_pkg::cmd_t                 cmd,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sha1sh_pkg::M_TDATA_W-1:0] m_tdata
);
    import sha1sh_pkg::*;

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_EMIT
    } back_state_t;

    back_state_t state_reg;
    logic [3:0]  wcnt_reg;
    logic [6:0]  round_reg;
    logic        closes_reg;
    logic [31:0] vars_reg  [5];
    logic [31:0] chain_reg [5];
    logic [31:0] sched_reg [16];
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [31:0] sched_xor;
    logic [31:0] w_next;
    logic [31:0] a_next;
    logic        load_fire;
    logic        out_free;

    assign cmd_ready = (state_reg == B_LOAD);
    assign load_fire = cmd_valid && cmd_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // The schedule window holds W[t..t+15] at round t, so the next word
    // always comes from the same four taps.
    always_comb begin
        sched_xor = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_next    = {sched_xor[30:0], sched_xor[31]};
        a_next    = {vars_reg[0][26:0], vars_reg[0][31:27]}
                  + mix_fn(round_reg, vars_reg[1], vars_reg[2], vars_reg[3])
                  + vars_reg[4] + sched_reg[0] + round_k(round_reg);
    end

    always_ff @(posedge aclk) begin
        if (load_fire || state_reg == B_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= load_fire ? cmd.word : w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_LOAD;
            wcnt_reg     <= '0;
            round_reg    <= '0;
            closes_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                vars_reg[i]  <= '0;
                chain_reg[i] <= H_INIT[i];
            end
        end else begin
            // In the emit state the valid flag is set below instead.
            if (m_tvalid_reg && m_tready && state_reg != B_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_LOAD: begin
                    if (load_fire) begin
                        wcnt_reg <= wcnt_reg + 4'd1;
                        if (wcnt_reg == 4'hF) begin
                            closes_reg <= cmd.closes;
                            round_reg  <= '0;
                            state_reg  <= B_ROUND;
                            for (int i = 0; i < 5; i++) begin
                                vars_reg[i] <= chain_reg[i];
                            end
                        end
                    end
                end
                B_ROUND: begin
                    vars_reg[0] <= a_next;
                    vars_reg[1] <= vars_reg[0];
                    vars_reg[2] <= {vars_reg[1][1:0], vars_reg[1][31:2]};
                    vars_reg[3] <= vars_reg[2];
                    vars_reg[4] <= vars_reg[3];
                    round_reg   <= round_reg + 7'd1;
                    if (round_reg == LAST_ROUND) begin
                        state_reg <= B_ADD;
                    end
                end
                B_ADD: begin
                    round_reg <= '0;
                    for (int i = 0; i < 5; i++) begin
                        chain_reg[i] <= chain_reg[i] + vars_reg[i];
                    end
                    state_reg <= closes_reg ? B_EMIT : B_LOAD;
                end
                B_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {chain_reg[4], chain_reg[3], chain_reg[2],
                                         chain_reg[1], chain_reg[0]};
                        for (int i = 0; i < 5; i++) begin
                            chain_reg[i] <= H_INIT[i];
                        end
                        state_reg <= B_LOAD;
                    end
                end
                default: begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1sh_pkg::*;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } msg_word_t;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_ALTERNATE} fill_t;

    localparam int PHASE_WORDS = 406;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    msg_word_t        pending_q[$];
    logic [159:0]     digest_q[$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic             start_hold = 1'b0;
    int               hold_left = 0;
    int               mismatch_count = 0;

    // Running hash state of the message currently being accepted.
    logic [31:0]      chain_h [5];
    logic [31:0]      msg_blk [16];
    logic [3:0]       blk_fill;
    logic [63:0]      msg_bits;

    sha1_stream_hasher_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic compress_chain();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        logic [31:0] sched [16];
        sched = msg_blk;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                w = sched[r];
            end else begin
                w = rotl(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^
                         sched[(r + 2) & 15] ^ sched[r & 15], 1);
                sched[r & 15] = w;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rotl(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic load_word(input logic [31:0] w);
        msg_blk[blk_fill] = w;
        blk_fill = blk_fill + 4'd1;
        if (blk_fill == 4'd0) begin
            compress_chain();
        end
    endtask

    task automatic restart_message();
        foreach (chain_h[i]) chain_h[i] = H_INIT[i];
        foreach (msg_blk[i]) msg_blk[i] = '0;
        blk_fill = '0;
        msg_bits = '0;
    endtask

    // Folds one accepted request into the hash; a last word pads the
    // message, finishes it and queues the digest it must produce.
    task automatic predict_word(input logic [31:0] data, input logic [2:0] nb,
                                input logic last);
        int unsigned n;
        logic [31:0] keep;
        n = (!last || nb > FULL_WORD_BYTES) ? 4 : int'(nb);
        msg_bits += 64'(n * 8);
        if (!last) begin
            load_word(data);
        end else begin
            if (n == 4) begin
                load_word(data);
                load_word(PAD_MARK);
            end else begin
                keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
                load_word((data & keep) | (PAD_MARK >> (8 * n)));
            end
            while (blk_fill != LEN_SLOT) load_word(32'h0);
            load_word(msg_bits[63:32]);
            load_word(msg_bits[31:0]);
            digest_q.push_back({chain_h[4], chain_h[3], chain_h[2], chain_h[1], chain_h[0]});
            restart_message();
        end
    endtask

    function automatic logic [31:0] fill_word(input fill_t style, input int idx);
        case (style)
            FILL_ZEROS:     return 32'h0000_0000;
            FILL_ONES:      return 32'hFFFF_FFFF;
            FILL_ALTERNATE: return idx[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            default:        return $urandom;
        endcase
    endfunction

    // Queues a message of body_words full words and a closing last word.
    task automatic queue_message(input int body_words, input logic [2:0] tail_bytes,
                                 input fill_t style, input bit odd_counts);
        msg_word_t item;
        for (int i = 0; i < body_words; i++) begin
            item.data = fill_word(style, i);
            item.nbytes = (odd_counts && $urandom_range(7) == 0) ?
                          3'($urandom_range(7)) : FULL_WORD_BYTES;
            item.last = 1'b0;
            pending_q.push_back(item);
        end
        item.data = fill_word(style, body_words);
        item.nbytes = tail_bytes;
        item.last = 1'b1;
        pending_q.push_back(item);
    endtask

    task automatic queue_random_phase();
        int added;
        int pick;
        int body;
        fill_t style;
        added = 0;
        while (added < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                body = $urandom_range(15);
            end else if (pick < 85) begin
                body = $urandom_range(17, 12);
            end else if (pick < 97) begin
                body = $urandom_range(40, 18);
            end else begin
                body = $urandom_range(100, 60);
            end
            pick = $urandom_range(9);
            style = (pick == 0) ? FILL_ZEROS : (pick == 1) ? FILL_ONES : FILL_RANDOM;
            queue_message(body, 3'($urandom_range(7)), style, 1'b1);
            added += body + 1;
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || digest_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        msg_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_tdata <= {5'b0, nxt.nbytes, nxt.data};
                    s_tlast <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (start_hold) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        logic [159:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("digest %h with no message pending", m_tdata));
                end else begin
                    want = digest_q.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (m_tdata[32 * i +: 32] !== want[32 * i +: 32]) begin
                            report_mismatch($sformatf("digest_h%0d got %h expected %h",
                                                      i, m_tdata[32 * i +: 32],
                                                      want[32 * i +: 32]));
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        msg_word_t item;
        restart_message();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty message; the invalid bytes of the closing word must not count.
        queue_message(0, 3'd0, FILL_ONES, 1'b0);
        item.data = 32'h6162_63FF;
        item.nbytes = 3'd3;
        item.last = 1'b1;
        pending_q.push_back(item);
        // Every count on a lone last word, including the ones that act as four.
        queue_message(0, 3'd1, FILL_ONES, 1'b0);
        queue_message(0, 3'd2, FILL_ZEROS, 1'b0);
        queue_message(0, 3'd4, FILL_ONES, 1'b0);
        queue_message(0, 3'd5, FILL_ZEROS, 1'b0);
        queue_message(0, 3'd6, FILL_ONES, 1'b0);
        queue_message(0, 3'd7, FILL_RANDOM, 1'b0);
        // Counts other than four on body words are ignored.
        item.data = 32'hFFFF_FFFF;
        item.nbytes = 3'd0;
        item.last = 1'b0;
        pending_q.push_back(item);
        item.data = 32'h0000_0000;
        item.nbytes = 3'd7;
        pending_q.push_back(item);
        item.data = $urandom;
        item.nbytes = 3'd4;
        item.last = 1'b1;
        pending_q.push_back(item);
        // The marker lands in the length slot, so padding spills into a second block.
        queue_message(13, 3'd4, FILL_ALTERNATE, 1'b0);
        queue_random_phase();

        // Stall the result side long enough for the input to back up.
        repeat (100) @(negedge aclk);
        start_hold = 1'b1;
        @(negedge aclk);
        start_hold = 1'b0;
        wait_drained();

        send_idle_pct = 73;
        recv_stall_pct = 0;
        queue_random_phase();
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 73;
        queue_random_phase();
        wait_drained();

        send_idle_pct = 24;
        recv_stall_pct = 24;
        queue_random_phase();
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sha1sh_pkg.sv
hw/rtl/sha1sh_front.sv
hw/rtl/sha1sh_fifo.sv
hw/rtl/sha1sh_back.sv
hw/rtl/sha1_stream_hasher_core.sv
test/tb.sv
